>>> hdl/dsd_pkg.sv
package dsd_pkg;

  // Input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_WBYTE = 2'd2;
  localparam logic [1:0] CMD_WLEN  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_LIT_OVER   = 3'd1;
  localparam logic [2:0] ERR_LIT_TRUNC  = 3'd2;
  localparam logic [2:0] ERR_CODE_TRUNC = 3'd3;
  localparam logic [2:0] ERR_WORD_OVER  = 3'd4;

  localparam logic [7:0] HINT_RESET = 8'd32;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_HINT    = 6'b000010,
    PH_COUNT   = 6'b000100,
    PH_LITERAL = 6'b001000,
    PH_CODE_HI = 6'b010000,
    PH_CODE_LO = 6'b100000
  } phase_e;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_WORD   = 5'b01000,
    ST_STATUS = 5'b10000
  } ctl_e;

endpackage

>>> hdl/dsd_in_if.sv
interface dsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        last_in;
  logic [7:0]  data_byte;
  logic [31:0] expected_size;
  logic [15:0] word_code;
  logic [4:0]  word_pos;
  logic [5:0]  word_len;

  modport source (
    output valid, cmd, last_in, data_byte, expected_size, word_code, word_pos, word_len,
    input  ready
  );
  modport sink (
    input  valid, cmd, last_in, data_byte, expected_size, word_code, word_pos, word_len,
    output ready
  );
endinterface

>>> hdl/dsd_out_if.sv
interface dsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       run_last;

  modport source (
    output valid, kind, out_byte, error_code, run_last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, error_code, run_last,
    output ready
  );
endinterface

>>> hdl/dictionary_substitution_decompressor_unit.sv
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   cmd, last_in, data_byte, expected_size, word_code,
//                             word_pos, word_len
// out_o    out  valid/ready   kind, out_byte, error_code, run_last
// cfg      in   cfg_we_i      cfg_wdata_i = hint_bytes
//
// Throughput: one transaction per cycle while the output register can take a result.
// After the second code byte the block reads the length store, then streams the word
// bytes from the word-store read port, then gives a trailing status if the frame closed
// on that word. A last literal byte that closes a frame is followed by a status result.
// Reset: a clearing pass zeroes all DICT_WORDS entries of the length store (65536 by
// default); no input transaction is taken meanwhile, config writes are.
// Stalls: out_o.ready low freezes the result register and holds off in_i.ready.
module dictionary_substitution_decompressor_unit
  import dsd_pkg::*;
#(
  parameter int DICT_WORDS     = 65536,
  parameter int MAX_WORD_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsd_in_if.sink     in_i,
  dsd_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int CODE_W = $clog2(DICT_WORDS);
  localparam int LEN_W  = $clog2(MAX_WORD_BYTES + 1);
  localparam int WA_W   = $clog2(DICT_WORDS * MAX_WORD_BYTES);

  // control state
  ctl_e              state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [CODE_W-1:0] clr_q, clr_d;
  logic [7:0]        hint_q;
  logic [7:0]        hint_left_q, hint_left_d;
  logic [7:0]        lit_left_q, lit_left_d;
  logic [31:0]       out_left_q, out_left_d;
  logic [7:0]        code_hi_q, code_hi_d;

  // work registers for one code lookup
  logic [CODE_W-1:0] code_q, code_d;
  logic              code_ok_q, code_ok_d;
  logic              last_q, last_d;
  logic [WA_W-1:0]   waddr_q, waddr_d;
  logic [LEN_W-1:0]  wcnt_q, wcnt_d;
  logic [2:0]        fin_err_q, fin_err_d;

  // result register
  logic              out_vld_q, out_vld_d;
  logic [1:0]        kind_q;
  logic [7:0]        byte_q;
  logic [2:0]        err_q;
  logic              rlast_q;

  logic              load;
  logic [1:0]        ld_kind;
  logic [7:0]        ld_byte;
  logic [2:0]        ld_err;
  logic              ld_rlast;

  // memory ports
  logic              len_we, len_re;
  logic [CODE_W-1:0] len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;
  logic              word_we, word_re;
  logic [WA_W-1:0]   word_waddr, word_raddr;
  logic [7:0]        word_rdata;

  logic              out_free, in_acc;
  logic [15:0]       code_in;
  logic              wcode_ok, wpos_ok;
  logic [6:0]        wlen_sat;
  logic [31:0]       wr_addr_w, base_w;
  logic [LEN_W-1:0]  len_eff;
  logic [7:0]        hint_dec;
  logic [7:0]        lit_dec;
  logic [31:0]       out_dec;

  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_RUN) && out_free;
  assign in_acc = in_i.valid && in_i.ready;

  // dictionary write decode
  assign code_in  = {code_hi_q, in_i.data_byte};
  assign wcode_ok = {1'b0, in_i.word_code} < 17'(DICT_WORDS);
  assign wpos_ok  = 7'(in_i.word_pos) < 7'(MAX_WORD_BYTES);
  always_comb begin
    if (in_i.word_len < 6'd2) begin
      wlen_sat = 7'd0;
    end else if (7'(in_i.word_len) > 7'(MAX_WORD_BYTES)) begin
      wlen_sat = 7'(MAX_WORD_BYTES);
    end else begin
      wlen_sat = 7'(in_i.word_len);
    end
  end
  assign wr_addr_w = 32'(in_i.word_code[CODE_W-1:0]) * 32'(MAX_WORD_BYTES)
                   + 32'(in_i.word_pos);
  assign word_waddr = wr_addr_w[WA_W-1:0];
  assign word_we    = in_acc && (in_i.cmd == CMD_WBYTE) && wcode_ok && wpos_ok;
  assign base_w     = 32'(code_q) * 32'(MAX_WORD_BYTES);

  // unloaded or out-of-range codes behave as length zero
  assign len_eff  = code_ok_q ? len_rdata : '0;
  assign hint_dec = (hint_left_q != 8'd0) ? hint_left_q - 8'd1 : hint_left_q;
  assign lit_dec  = (lit_left_q != 8'd0) ? lit_left_q - 8'd1 : lit_left_q;
  assign out_dec  = (out_left_q != 32'd0) ? out_left_q - 32'd1 : out_left_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    clr_d       = clr_q;
    hint_left_d = hint_left_q;
    lit_left_d  = lit_left_q;
    out_left_d  = out_left_q;
    code_hi_d   = code_hi_q;
    code_d      = code_q;
    code_ok_d   = code_ok_q;
    last_d      = last_q;
    waddr_d     = waddr_q;
    wcnt_d      = wcnt_q;
    fin_err_d   = fin_err_q;
    load        = 1'b0;
    ld_kind     = KIND_BYTE;
    ld_byte     = 8'd0;
    ld_err      = ERR_NONE;
    ld_rlast    = 1'b1;
    len_we      = 1'b0;
    len_waddr   = clr_q;
    len_wdata   = '0;
    len_re      = 1'b0;
    len_raddr   = code_in[CODE_W-1:0];
    word_re     = 1'b0;
    word_raddr  = waddr_q + WA_W'(1);

    case (state_q)
      ST_CLEAR: begin
        len_we = 1'b1;
        if (clr_q == CODE_W'(DICT_WORDS - 1)) begin
          state_d = ST_RUN;
        end else begin
          clr_d = clr_q + CODE_W'(1);
        end
      end

      ST_RUN: begin
        if (in_acc) begin
          case (in_i.cmd)
            CMD_START: begin
              out_left_d  = in_i.expected_size;
              lit_left_d  = 8'd0;
              code_hi_d   = 8'd0;
              hint_left_d = hint_q;
              phase_d     = (hint_q != 8'd0) ? PH_HINT : PH_COUNT;
            end
            CMD_BYTE: begin
              case (phase_q)
                PH_HINT: begin
                  hint_left_d = hint_dec;
                  if (in_i.last_in) begin
                    load    = 1'b1;
                    ld_kind = KIND_OK;
                    phase_d = PH_IDLE;
                  end else if (hint_dec == 8'd0) begin
                    phase_d = PH_COUNT;
                  end
                end
                PH_COUNT: begin
                  if (32'(in_i.data_byte) > out_left_q) begin
                    load    = 1'b1;
                    ld_kind = KIND_FAIL;
                    ld_err  = ERR_LIT_OVER;
                    phase_d = PH_IDLE;
                  end else if (in_i.data_byte != 8'd0 && in_i.last_in) begin
                    load    = 1'b1;
                    ld_kind = KIND_FAIL;
                    ld_err  = ERR_LIT_TRUNC;
                    phase_d = PH_IDLE;
                  end else if (in_i.data_byte == 8'd0) begin
                    if (in_i.last_in) begin
                      load    = 1'b1;
                      ld_kind = (out_left_q == 32'd0) ? KIND_OK : KIND_FAIL;
                      ld_err  = (out_left_q == 32'd0) ? ERR_NONE : ERR_CODE_TRUNC;
                      phase_d = PH_IDLE;
                    end else begin
                      phase_d = PH_CODE_HI;
                    end
                  end else begin
                    lit_left_d = in_i.data_byte;
                    phase_d    = PH_LITERAL;
                  end
                end
                PH_LITERAL: begin
                  if (in_i.last_in && lit_left_q > 8'd1) begin
                    load    = 1'b1;
                    ld_kind = KIND_FAIL;
                    ld_err  = ERR_LIT_TRUNC;
                    phase_d = PH_IDLE;
                  end else begin
                    load       = 1'b1;
                    ld_byte    = in_i.data_byte;
                    out_left_d = out_dec;
                    lit_left_d = lit_dec;
                    if (lit_dec == 8'd0) begin
                      if (in_i.last_in) begin
                        // frame closes right behind this byte
                        ld_rlast  = 1'b0;
                        fin_err_d = (out_dec == 32'd0) ? ERR_NONE : ERR_CODE_TRUNC;
                        state_d   = ST_STATUS;
                      end else begin
                        phase_d = PH_CODE_HI;
                      end
                    end
                  end
                end
                PH_CODE_HI: begin
                  code_hi_d = in_i.data_byte;
                  if (in_i.last_in) begin
                    load    = 1'b1;
                    ld_kind = KIND_FAIL;
                    ld_err  = ERR_CODE_TRUNC;
                    phase_d = PH_IDLE;
                  end else begin
                    phase_d = PH_CODE_LO;
                  end
                end
                PH_CODE_LO: begin
                  len_re    = 1'b1;
                  code_d    = code_in[CODE_W-1:0];
                  code_ok_d = (code_in != 16'd0) && ({1'b0, code_in} < 17'(DICT_WORDS));
                  last_d    = in_i.last_in;
                  state_d   = ST_LOOKUP;
                end
                default: begin
                  // idle: stray encoded bytes are dropped
                end
              endcase
            end
            CMD_WLEN: begin
              len_we    = wcode_ok;
              len_waddr = in_i.word_code[CODE_W-1:0];
              len_wdata = wlen_sat[LEN_W-1:0];
            end
            default: begin
              // word byte write handled by word_we
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        if (out_free) begin
          if (32'(len_eff) > out_left_q) begin
            load    = 1'b1;
            ld_kind = KIND_FAIL;
            ld_err  = ERR_WORD_OVER;
            phase_d = PH_IDLE;
            state_d = ST_RUN;
          end else if (len_eff == '0) begin
            if (last_q) begin
              load    = 1'b1;
              ld_kind = KIND_OK;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_COUNT;
            end
            state_d = ST_RUN;
          end else begin
            out_left_d = out_left_q - 32'(len_eff);
            word_re    = 1'b1;
            word_raddr = base_w[WA_W-1:0];
            waddr_d    = base_w[WA_W-1:0];
            wcnt_d     = len_eff;
            state_d    = ST_WORD;
          end
        end
      end

      ST_WORD: begin
        if (out_free) begin
          load    = 1'b1;
          ld_byte = word_rdata;
          if (wcnt_q == LEN_W'(1)) begin
            if (last_q) begin
              ld_rlast  = 1'b0;
              fin_err_d = ERR_NONE;
              state_d   = ST_STATUS;
            end else begin
              phase_d = PH_COUNT;
              state_d = ST_RUN;
            end
          end else begin
            // fetch the next byte while this one goes out
            ld_rlast = 1'b0;
            wcnt_d   = wcnt_q - LEN_W'(1);
            word_re  = 1'b1;
            waddr_d  = waddr_q + WA_W'(1);
          end
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = (fin_err_q == ERR_NONE) ? KIND_OK : KIND_FAIL;
          ld_err  = fin_err_q;
          phase_d = PH_IDLE;
          state_d = ST_RUN;
        end
      end

      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  assign out_vld_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_IDLE;
      clr_q       <= '0;
      hint_q      <= HINT_RESET;
      hint_left_q <= 8'd0;
      lit_left_q  <= 8'd0;
      out_left_q  <= 32'd0;
      code_hi_q   <= 8'd0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      hint_left_q <= hint_left_d;
      lit_left_q  <= lit_left_d;
      out_left_q  <= out_left_d;
      code_hi_q   <= code_hi_d;
      out_vld_q   <= out_vld_d;
      if (cfg_we_i) begin
        hint_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    code_ok_q <= code_ok_d;
    last_q    <= last_d;
    waddr_q   <= waddr_d;
    wcnt_q    <= wcnt_d;
    fin_err_q <= fin_err_d;
    if (load) begin
      kind_q  <= ld_kind;
      byte_q  <= ld_byte;
      err_q   <= ld_err;
      rlast_q <= ld_rlast;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = kind_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.error_code = err_q;
  assign out_o.run_last   = rlast_q;

  // word lengths, zeroed by the clearing pass
  dsd_ram #(
    .WIDTH (LEN_W),
    .DEPTH (DICT_WORDS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // word bytes, code-major
  dsd_ram #(
    .WIDTH (8),
    .DEPTH (DICT_WORDS * MAX_WORD_BYTES)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (in_i.data_byte),
    .re_i    (word_re),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_i.ready)
    else $error("input taken during clearing pass");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q != KIND_BYTE |-> rlast_q)
    else $error("status result not marked last");

  a_byte_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q == KIND_BYTE |-> err_q == ERR_NONE)
    else $error("byte result carries error code");

  a_code_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.cmd == CMD_BYTE && phase_q == PH_CODE_LO |=> state_q == ST_LOOKUP)
    else $error("second code byte did not start lookup");

  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WORD |-> wcnt_q != '0)
    else $error("word streaming with zero count");

endmodule

>>> hdl/dsd_ram.sv
module dsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/dictionary_substitution_decompressor_unit_test.sv
module dictionary_substitution_decompressor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dsd_pkg::*;

  // Bytes per dictionary word, as the block is built here.
  localparam int WORD_BYTES = 32;
  // Cycles the receiver holds off once, long enough to back up the input.
  localparam int HOLD_CYCLES = 400;
  // Quiet cycles before giving up, set well above the length-store clearing
  // pass after reset, during which no transaction moves.
  localparam int STALL_LIMIT = 300000;
  // Extra cycles after the last expected result before a config write or the end.
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_N = 6;
  // Codes that get real word contents; random length loads of two or more only target these.
  localparam logic [15:0] WORD_POOL [0:POOL_N-1] = '{
    16'hFFFF, 16'h0001, 16'h8000, 16'h00FF, 16'h0000, 16'h5A5A
  };

  typedef struct packed {
    logic [1:0]  cmd;
    logic        last_in;
    logic [7:0]  data_byte;
    logic [31:0] expected_size;
    logic [15:0] word_code;
    logic [4:0]  word_pos;
    logic [5:0]  word_len;
  } dsd_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       run_last;
  } dsd_result_t;

  // Frame decoder mirror plus the queue of decoded results still to arrive.
  class dsd_scoreboard;
    bit [7:0]    word_bytes [int];
    bit [5:0]    word_len_tab [0:65535];
    bit [7:0]    hint_cfg = HINT_RESET;
    phase_e      phase = PH_IDLE;
    bit [7:0]    hint_left;
    bit [7:0]    lit_left;
    bit [7:0]    code_high;
    bit [31:0]   out_left;
    dsd_result_t decoded_q[$];
    dsd_result_t run_q[$];
    int          n_errors;
    int          n_bytes;
    int          n_ok;
    int          n_fail;
    int          n_frames;

    function int outstanding();
      return decoded_q.size();
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] b, logic [2:0] err);
      dsd_result_t r;
      r.kind       = kind;
      r.out_byte   = b;
      r.error_code = err;
      r.run_last   = 1'b0;
      run_q.push_back(r);
    endfunction

    function void end_frame(logic [2:0] err);
      phase = PH_IDLE;
      if (err != ERR_NONE) emit(KIND_FAIL, 8'h00, err);
      else emit(KIND_OK, 8'h00, ERR_NONE);
    endfunction

    function void literals_done(bit last);
      if (!last) phase = PH_CODE_HI;
      else if (out_left == 0) end_frame(ERR_NONE);
      else end_frame(ERR_CODE_TRUNC);
    endfunction

    function void decode_byte(logic [7:0] b, bit last);
      logic [15:0] code;
      int          len;
      int          key;
      case (phase)
        PH_HINT: begin
          if (hint_left > 0) hint_left--;
          if (last) end_frame(ERR_NONE);
          else if (hint_left == 0) phase = PH_COUNT;
        end
        PH_COUNT: begin
          // overrun wins over truncation
          if (32'(b) > out_left) end_frame(ERR_LIT_OVER);
          else if (b != 0 && last) end_frame(ERR_LIT_TRUNC);
          else if (b == 0) literals_done(last);
          else begin
            lit_left = b;
            phase    = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          if (last && lit_left > 1) begin
            end_frame(ERR_LIT_TRUNC);
          end else begin
            emit(KIND_BYTE, b, ERR_NONE);
            if (out_left > 0) out_left--;
            if (lit_left > 0) lit_left--;
            if (lit_left == 0) literals_done(last);
          end
        end
        PH_CODE_HI: begin
          code_high = b;
          if (last) end_frame(ERR_CODE_TRUNC);
          else phase = PH_CODE_LO;
        end
        PH_CODE_LO: begin
          code = {code_high, b};
          if (code != 0) begin
            len = int'(word_len_tab[code]);
            if (32'(len) > out_left) begin
              end_frame(ERR_WORD_OVER);
              return;
            end
            for (int i = 0; i < len; i++) begin
              key = int'({code, 5'(i)});
              emit(KIND_BYTE, word_bytes.exists(key) ? word_bytes[key] : 8'h00, ERR_NONE);
            end
            out_left = out_left - 32'(len);
          end
          if (last) end_frame(ERR_NONE);
          else phase = PH_COUNT;
        end
        default: ;
      endcase
    endfunction

    // One accepted input transaction: update state, queue what it decodes to.
    function void note_input(dsd_item_t it);
      int wl;
      run_q.delete();
      case (it.cmd)
        CMD_START: begin
          // a start inside an open frame drops it silently
          n_frames++;
          out_left  = it.expected_size;
          lit_left  = 0;
          code_high = 0;
          hint_left = hint_cfg;
          if (hint_cfg != 0) phase = PH_HINT;
          else phase = PH_COUNT;
        end
        CMD_BYTE:  decode_byte(it.data_byte, it.last_in);
        CMD_WBYTE: word_bytes[int'({it.word_code, it.word_pos})] = it.data_byte;
        CMD_WLEN: begin
          wl = int'(it.word_len);
          if (wl < 2) wl = 0;
          else if (wl > WORD_BYTES) wl = WORD_BYTES;
          word_len_tab[it.word_code] = 6'(wl);
        end
        default: ;
      endcase
      if (run_q.size() > 0) run_q[run_q.size()-1].run_last = 1'b1;
      foreach (run_q[i]) decoded_q.push_back(run_q[i]);
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        n_errors++;
        $error("%s mismatch: expected %0d actual %0d", name, e, a);
      end
    endfunction

    function void check_result(dsd_result_t act);
      dsd_result_t exp_r;
      case (act.kind)
        KIND_BYTE: n_bytes++;
        KIND_OK:   n_ok++;
        default:   n_fail++;
      endcase
      if (decoded_q.size() == 0) begin
        n_errors++;
        $error("unexpected result: kind %0d byte %0d error %0d",
               act.kind, act.out_byte, act.error_code);
        return;
      end
      exp_r = decoded_q.pop_front();
      compare_field("kind", exp_r.kind, act.kind);
      compare_field("out_byte", exp_r.out_byte, act.out_byte);
      compare_field("error_code", exp_r.error_code, act.error_code);
      compare_field("run_last", exp_r.run_last, act.run_last);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  dsd_in_if  in_bus ();
  dsd_out_if out_bus ();

  dictionary_substitution_decompressor_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  dsd_scoreboard sb = new();

  dsd_item_t   stim_q[$];
  int          word_fill [logic [15:0]];  // written prefix length per pool code
  int          n_sent;
  int          quiet_cycles;
  bit          idle_en;
  bit          hold_req;
  int          hold_left;
  dsd_result_t seen_result;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: every accepted transaction goes straight to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      seen_result.kind       = out_bus.kind;
      seen_result.out_byte   = out_bus.out_byte;
      seen_result.error_code = out_bus.error_code;
      seen_result.run_last   = out_bus.run_last;
      sb.check_result(seen_result);
    end
  end

  // Receiver ready: random gaps, or one long hold-off counted right here.
  initial begin
    out_bus.ready = 1'b0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req       = 1'b0;
        hold_left      = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(idle_en && $urandom_range(99) < 12);
      end
    end
  end

  // Watchdog on cycles where neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Fields a command ignores still get random values, so every bit toggles.
  function automatic dsd_item_t blank_item();
    dsd_item_t it;
    it.cmd           = 2'($urandom);
    it.last_in       = 1'($urandom);
    it.data_byte     = 8'($urandom);
    it.expected_size = $urandom;
    it.word_code     = 16'($urandom);
    it.word_pos      = 5'($urandom);
    it.word_len      = 6'($urandom);
    return it;
  endfunction

  function automatic dsd_item_t start_item(logic [31:0] size);
    dsd_item_t it = blank_item();
    it.cmd           = CMD_START;
    it.expected_size = size;
    return it;
  endfunction

  function automatic dsd_item_t enc_item(logic [7:0] b, logic last);
    dsd_item_t it = blank_item();
    it.cmd       = CMD_BYTE;
    it.data_byte = b;
    it.last_in   = last;
    return it;
  endfunction

  function automatic dsd_item_t wbyte_item(logic [15:0] code, logic [4:0] pos, logic [7:0] b);
    dsd_item_t it = blank_item();
    it.cmd       = CMD_WBYTE;
    it.word_code = code;
    it.word_pos  = pos;
    it.data_byte = b;
    return it;
  endfunction

  function automatic dsd_item_t wlen_item(logic [15:0] code, logic [5:0] len);
    dsd_item_t it = blank_item();
    it.cmd       = CMD_WLEN;
    it.word_code = code;
    it.word_len  = len;
    return it;
  endfunction

  // Queue one group: literal count, literals, big-endian code.
  // Returns how many decoded bytes the group should produce.
  function automatic int push_group(int count, logic [15:0] code);
    stim_q.push_back(enc_item(8'(count), 1'b0));
    repeat (count) stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(enc_item(code[15:8], 1'b0));
    stim_q.push_back(enc_item(code[7:0], 1'b0));
    return count + ((code != 0) ? int'(sb.word_len_tab[code]) : 0);
  endfunction

  // Inputs change on the falling edge; acceptance is seen on the rising edge.
  // valid stays high between back-to-back transactions.
  task automatic send_item(input dsd_item_t it);
    if (idle_en && $urandom_range(99) < 8) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.cmd           <= it.cmd;
    in_bus.last_in       <= it.last_in;
    in_bus.data_byte     <= it.data_byte;
    in_bus.expected_size <= it.expected_size;
    in_bus.word_code     <= it.word_code;
    in_bus.word_pos      <= it.word_pos;
    in_bus.word_len      <= it.word_len;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(it);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_all();
    foreach (stim_q[i]) send_item(stim_q[i]);
    stim_q.delete();
  endtask

  // Sender pauses until every decoded result is back, then lets the block settle.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_hint(input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.hint_cfg = v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Bytes first, then the length, so no unwritten word byte is ever read.
  task automatic load_word(input logic [15:0] code, input int fill, input logic [5:0] len);
    for (int p = 0; p < fill; p++) stim_q.push_back(wbyte_item(code, 5'(p), 8'($urandom)));
    stim_q.push_back(wlen_item(code, len));
    word_fill[code] = fill;
    send_all();
  endtask

  function automatic logic [15:0] pick_code();
    if ($urandom_range(9) < 7) return WORD_POOL[$urandom_range(0, POOL_N-1)];
    return 16'($urandom);
  endfunction

  // Mostly well-formed frames with random content; some with a wrong size,
  // some cut short with last, some cut short and left open for a restart.
  task automatic random_frame();
    int          nominal;
    int          cut;
    int          mode;
    int          count;
    logic [31:0] size;
    nominal = 0;
    stim_q.push_back(start_item(32'd0));
    repeat (sb.hint_cfg) stim_q.push_back(enc_item(8'($urandom), 1'b0));
    repeat ($urandom_range(1, 3)) begin
      count = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 4);
      nominal += push_group(count, pick_code());
    end
    stim_q[stim_q.size()-1].last_in = 1'b1;
    mode = $urandom_range(10);
    size = 32'(nominal);
    case (mode)
      6: size = 32'(nominal) + $urandom_range(1, 20);
      7: size = (nominal > 0) ? $urandom_range(0, nominal - 1) : 32'd0;
      8: size = $urandom;
      9, 10: begin
        cut    = $urandom_range(1, stim_q.size() - 2);
        stim_q = stim_q[0:cut];
        // mode 10 leaves the frame open; the next start abandons it
        if (mode == 9) stim_q[cut].last_in = 1'b1;
      end
      default: ;
    endcase
    stim_q[0].expected_size = size;
    send_all();
  endtask

  task automatic random_dict_op();
    logic [15:0] code;
    code = WORD_POOL[$urandom_range(0, POOL_N-1)];
    case ($urandom_range(3))
      0: begin
        if (word_fill[code] < WORD_BYTES) begin
          stim_q.push_back(wbyte_item(code, 5'(word_fill[code]), 8'($urandom)));
          word_fill[code]++;
        end else begin
          stim_q.push_back(wbyte_item(code, 5'($urandom), 8'($urandom)));
        end
      end
      1: stim_q.push_back(wbyte_item(code, 5'($urandom_range(0, word_fill[code] - 1)),
                                     8'($urandom)));
      2: begin
        if (word_fill[code] == WORD_BYTES && $urandom_range(1))
          stim_q.push_back(wlen_item(code, 6'($urandom_range(2, 63))));
        else if ($urandom_range(3) == 0)
          stim_q.push_back(wlen_item(code, 6'($urandom_range(0, 1))));
        else
          stim_q.push_back(wlen_item(code, 6'($urandom_range(2, word_fill[code]))));
      end
      default: begin
        // arbitrary code: bytes anywhere, lengths only ever cleared
        if ($urandom_range(1))
          stim_q.push_back(wbyte_item(16'($urandom), 5'($urandom), 8'($urandom)));
        else stim_q.push_back(wlen_item(16'($urandom), 6'($urandom_range(0, 1))));
      end
    endcase
    send_all();
  endtask

  task automatic random_traffic(input int n);
    int first;
    int pick;
    first = n_sent;
    while (n_sent - first < n) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        random_frame();
      end else if (pick < 9) begin
        random_dict_op();
      end else begin
        // stray bytes: ignored unless a frame was left open
        repeat ($urandom_range(1, 3)) stim_q.push_back(enc_item(8'($urandom), 1'($urandom)));
        send_all();
      end
    end
  endtask

  initial begin
    int nominal;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 8'h00;
    in_bus.valid         = 1'b0;
    in_bus.cmd           = CMD_START;
    in_bus.last_in       = 1'b0;
    in_bus.data_byte     = 8'h00;
    in_bus.expected_size = 32'h0;
    in_bus.word_code     = 16'h0;
    in_bus.word_pos      = 5'h0;
    in_bus.word_len      = 6'h0;
    idle_en              = 1'b1;
    hold_req             = 1'b0;
    n_sent               = 0;
    quiet_cycles         = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bytes with no frame open are dropped. The first transaction waits out
    // the clearing pass.
    stim_q.push_back(enc_item(8'hA5, 1'b1));
    stim_q.push_back(enc_item(8'h00, 1'b0));
    // Default hint count of 32: last arrives among the hint bytes -> success.
    stim_q.push_back(start_item(32'd10));
    stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b1));
    send_all();

    write_hint(8'd0);

    // long stretch with neither side idling: dictionary loads and the
    // exact-size frame
    idle_en = 1'b0;

    // Dictionary: a saturating length on the all-ones code, a loaded code
    // zero (never emitted), and one entry cleared by a short length.
    load_word(16'hFFFF, WORD_BYTES, 6'd63);
    load_word(16'h0001, 2, 6'd2);
    load_word(16'h8000, 5, 6'd5);
    load_word(16'h00FF, 4, 6'd4);
    load_word(16'h0000, 2, 6'd2);
    load_word(16'h5A5A, 4, 6'd1);

    // Exact-size frame ending on the all-ones word: 32 bytes plus status
    // from one transaction. Code zero and an unloaded code emit nothing.
    stim_q.push_back(start_item(32'd36));
    nominal = push_group(2, 16'h0001);
    nominal += push_group(0, 16'h0000);
    nominal += push_group(0, 16'h1234);
    nominal += push_group(0, 16'hFFFF);
    stim_q[stim_q.size()-1].last_in = 1'b1;
    send_all();
    idle_en = 1'b1;

    // literal overrun
    stim_q.push_back(start_item(32'd1));
    stim_q.push_back(enc_item(8'd5, 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b1));
    // literal truncated mid-run; the closing byte is not passed through
    stim_q.push_back(start_item(32'd10));
    stim_q.push_back(enc_item(8'd3, 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b1));
    // literal truncated on the count byte itself
    stim_q.push_back(start_item(32'd10));
    stim_q.push_back(enc_item(8'd4, 1'b1));
    // code truncated: ends after literals with output still owed
    stim_q.push_back(start_item(32'd10));
    stim_q.push_back(enc_item(8'd1, 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b1));
    // code truncated after the high code byte
    stim_q.push_back(start_item(32'd10));
    stim_q.push_back(enc_item(8'd0, 1'b0));
    stim_q.push_back(enc_item(8'hFF, 1'b1));
    // word overrun: 32-byte word with 4 bytes left
    stim_q.push_back(start_item(32'd4));
    stim_q.push_back(enc_item(8'd0, 1'b0));
    stim_q.push_back(enc_item(8'hFF, 1'b0));
    stim_q.push_back(enc_item(8'hFF, 1'b1));
    // early finish on a code byte, huge expected size
    stim_q.push_back(start_item(32'hFFFF_FFFF));
    stim_q.push_back(enc_item(8'd1, 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(enc_item(8'h00, 1'b0));
    stim_q.push_back(enc_item(8'h00, 1'b1));
    // restart mid-literals, then an empty frame that finishes cleanly
    stim_q.push_back(start_item(32'd8));
    stim_q.push_back(enc_item(8'd2, 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(start_item(32'd0));
    stim_q.push_back(enc_item(8'h00, 1'b0));
    stim_q.push_back(enc_item(8'h00, 1'b0));
    stim_q.push_back(enc_item(8'h00, 1'b1));
    send_all();

    // Largest hint count, frame closed inside the hint bytes.
    write_hint(8'd255);
    stim_q.push_back(start_item(32'd5));
    stim_q.push_back(enc_item(8'($urandom), 1'b0));
    stim_q.push_back(enc_item(8'($urandom), 1'b1));
    send_all();

    write_hint(8'd1);
    random_traffic(8);

    // receiver holds off while frames keep coming: the block backs up
    write_hint(8'($urandom_range(2, 6)));
    hold_req = 1'b1;
    random_traffic(8);

    drain();
    $display("Covered %0d input transactions in %0d frames; %0d results checked",
             n_sent, sb.n_frames, sb.n_bytes + sb.n_ok + sb.n_fail);
    $display("  (%0d decoded bytes, %0d frames ok, %0d frames failed)",
             sb.n_bytes, sb.n_ok, sb.n_fail);
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
